// ===== src/lgf_pkg.sv =====
// shared types and constants for the largest eta gap finder
`timescale 1ns / 1ps
package lgf_pkg;

    localparam int MAX_PARTICLES = 256;
    localparam int ETA_W = 18;
    localparam int MOM_W = 32;
    localparam int TOL_W = 8;
    localparam int GAP_W = ETA_W + 3;

    localparam logic [1:0] CFG_ETA_LOW  = 2'd0;
    localparam logic [1:0] CFG_ETA_HIGH = 2'd1;
    localparam logic [1:0] CFG_GAP_TOL  = 2'd2;

    localparam logic [ETA_W-1:0] ETA_LOW_RST  = ETA_W'(-40960);
    localparam logic [ETA_W-1:0] ETA_HIGH_RST = ETA_W'(40960);
    localparam logic [TOL_W-1:0] GAP_TOL_RST  = TOL_W'(1);

    localparam logic [7:0] STATUS_FINAL = 8'd1;

    typedef struct packed {
        logic                    valid;
        logic signed [ETA_W-1:0] eta;
        logic [MOM_W-1:0]        mom_x;
        logic [MOM_W-1:0]        mom_y;
        logic [MOM_W-1:0]        mom_z;
        logic [MOM_W-1:0]        energy;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic scan;
    } t_cell_ctl;

endpackage

// ===== src/lgf_cell.sv =====
// one cell of the sorted particle chain
`timescale 1ns / 1ps
module lgf_cell
    import lgf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_entry    i_prev,
    input  logic      i_prev_beyond,
    input  t_entry    i_next,
    output t_entry    o_entry,
    output logic      o_beyond
);

    t_entry r_entry;
    t_entry n_entry;

    // cell sits past the insertion point of the new particle
    assign o_beyond = !r_entry.valid || (r_entry.eta > i_new.eta);
    assign o_entry  = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.scan) begin
            n_entry = i_next;
        end else if (i_ctl.ins) begin
            if (i_prev_beyond) begin
                n_entry = i_prev;
            end else if (o_beyond) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry.eta    <= n_entry.eta;
        r_entry.mom_x  <= n_entry.mom_x;
        r_entry.mom_y  <= n_entry.mom_y;
        r_entry.mom_z  <= n_entry.mom_z;
        r_entry.energy <= n_entry.energy;
    end

endmodule

// ===== src/largest_eta_gap_finder_core.sv =====
// top level: sorted insertion chain and largest eta gap scan
//
//  channel | direction | handshake               | content
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall  | status, eta, momenta, last
//  out     | output    | o_out_valid / i_out_stall| low and high edge, overflow
//  cfg     | input     | i_cfg_valid / o_cfg_ready| register index and data
//
// one particle beat per cycle is taken while loading; kept ones are inserted in place
// after the last beat the scan shifts the chain toward cell 0 until it is empty;
// input is stalled during the scan
// the scan finishes only when the output register is free
// reset (synchronous, active low) empties the chain and restores the registers
`timescale 1ns / 1ps
module largest_eta_gap_finder_core
    import lgf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [ETA_W-1:0]        i_cfg_data,
    // particle input
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_status,
    input  logic signed [ETA_W-1:0] i_eta,
    input  logic signed [MOM_W-1:0] i_mom_x,
    input  logic signed [MOM_W-1:0] i_mom_y,
    input  logic signed [MOM_W-1:0] i_mom_z,
    input  logic [MOM_W-1:0]        i_energy,
    input  logic                    i_last,
    // result output
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [MOM_W-1:0] o_low_mom_x,
    output logic signed [MOM_W-1:0] o_low_mom_y,
    output logic signed [MOM_W-1:0] o_low_mom_z,
    output logic [MOM_W-1:0]        o_low_energy,
    output logic signed [MOM_W-1:0] o_high_mom_x,
    output logic signed [MOM_W-1:0] o_high_mom_y,
    output logic signed [MOM_W-1:0] o_high_mom_z,
    output logic [MOM_W-1:0]        o_high_energy,
    output logic                    o_overflow
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // configuration registers
    logic signed [ETA_W-1:0] r_eta_low;
    logic signed [ETA_W-1:0] r_eta_high;
    logic [TOL_W-1:0]        r_gap_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_low  <= ETA_LOW_RST;
            r_eta_high <= ETA_HIGH_RST;
            r_gap_tol  <= GAP_TOL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ETA_LOW:  r_eta_low  <= i_cfg_data;
                CFG_ETA_HIGH: r_eta_high <= i_cfg_data;
                CFG_GAP_TOL:  r_gap_tol  <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    logic r_state;
    logic r_ovf;
    logic r_out_valid;

    // chain of cells
    t_entry    w_new;
    t_entry    w_cell [MAX_PARTICLES];
    logic      w_beyond [MAX_PARTICLES];
    t_cell_ctl w_ctl;
    t_entry    w_empty;

    logic w_accept;
    logic w_keep;
    logic w_full;

    assign o_in_stall = (r_state != ST_LOAD);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = w_cell[MAX_PARTICLES-1].valid;
    assign w_keep     = (i_status == STATUS_FINAL) && (i_eta >= r_eta_low)
                        && (i_eta <= r_eta_high);

    assign w_new = '{valid: 1'b1, eta: i_eta, mom_x: i_mom_x, mom_y: i_mom_y,
                     mom_z: i_mom_z, energy: i_energy};
    assign w_empty = '0;

    // scan bookkeeping
    t_entry w_head;
    t_entry w_succ;
    logic signed [GAP_W-1:0] w_gap;
    logic signed [GAP_W-1:0] w_thr;
    logic                    w_win;
    logic                    w_final;
    logic                    w_done;
    logic                    w_out_free;
    logic                    w_step;
    logic                    r_first;
    logic signed [GAP_W-1:0] r_best;
    t_entry                  r_low;
    t_entry                  r_high;
    t_entry                  w_cand_low;
    t_entry                  w_cand_high;

    assign w_head  = w_cell[0];
    assign w_succ  = w_cell[1];
    assign w_gap   = w_succ.valid ? (GAP_W'(w_succ.eta) - GAP_W'(w_head.eta)) : '0;
    assign w_thr   = r_best - GAP_W'({1'b0, r_gap_tol});
    assign w_win   = r_first || (w_gap > w_thr);
    assign w_final = !w_head.valid || !w_succ.valid;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_done  = (r_state == ST_SCAN) && w_final && w_out_free;
    // shift while scanning, except on a final step that must wait for the output
    assign w_step  = (r_state == ST_SCAN) && (!w_final || w_out_free);

    // the last kept position competes with a zero gap and a zero low edge
    assign w_cand_low  = w_succ.valid ? w_head : w_empty;
    assign w_cand_high = w_succ.valid ? w_succ : w_head;

    assign w_ctl.ins  = w_accept && w_keep && !w_full;
    assign w_ctl.scan = w_step;

    for (genvar g = 0; g < MAX_PARTICLES; g++) begin : g_chain
        lgf_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new         (w_new),
            .i_prev        ((g == 0) ? w_empty : w_cell[(g == 0) ? 0 : g-1]),
            .i_prev_beyond ((g == 0) ? 1'b0 : w_beyond[(g == 0) ? 0 : g-1]),
            .i_next        ((g == MAX_PARTICLES-1) ? w_empty
                             : w_cell[(g == MAX_PARTICLES-1) ? g : g+1]),
            .o_entry       (w_cell[g]),
            .o_beyond      (w_beyond[g])
        );
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_first     <= 1'b1;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (w_keep && w_full) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last) begin
                            r_state <= ST_SCAN;
                        end
                    end
                    r_first <= 1'b1;
                end
                ST_SCAN: begin
                    if (w_step) begin
                        r_first <= 1'b0;
                    end
                    if (w_done) begin
                        r_state     <= ST_LOAD;
                        r_ovf       <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    // running winner and result register
    t_entry r_res_low;
    t_entry r_res_high;
    logic   r_res_ovf;

    always_ff @(posedge i_clk) begin
        if (w_step && w_head.valid && w_win) begin
            r_best <= w_gap;
            r_low  <= w_cand_low;
            r_high <= w_cand_high;
        end
        if (w_done) begin
            r_res_ovf <= r_ovf;
            if (!w_head.valid) begin
                r_res_low  <= w_empty;
                r_res_high <= w_empty;
            end else if (w_win) begin
                r_res_low  <= w_cand_low;
                r_res_high <= w_cand_high;
            end else begin
                r_res_low  <= r_low;
                r_res_high <= r_high;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_low_mom_x   = r_res_low.mom_x;
    assign o_low_mom_y   = r_res_low.mom_y;
    assign o_low_mom_z   = r_res_low.mom_z;
    assign o_low_energy  = r_res_low.energy;
    assign o_high_mom_x  = r_res_high.mom_x;
    assign o_high_mom_y  = r_res_high.mom_y;
    assign o_high_mom_z  = r_res_high.mom_z;
    assign o_high_energy = r_res_high.energy;
    assign o_overflow    = r_res_ovf;

    // kept entries stay packed toward cell 0
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell[1].valid |-> w_cell[0].valid)
        else $error("chain has a hole at cell 0");

    // a finished scan leaves the chain empty and the overflow flag clear
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (!w_cell[0].valid && !r_ovf))
        else $error("chain not cleared after scan");

    // the result register is only loaded when it is free
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_out_free)
        else $error("result overwritten while stalled");

endmodule
